>>> hw/rtl/srpwm_pkg.sv
// Shared types and constants for the shift register PWM frame generator.
// Used by srpwm_cell, srpwm_ctrl and the top level; depends on nothing.
package srpwm_pkg;

    localparam int LEVEL_W = 8;
    localparam int PHASE_W = 9;
    localparam int SEL_W   = 3;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 9;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_INVERT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DEPTH  = 2'd1;

    localparam logic [PHASE_W-1:0] DEPTH_RESET = 9'd256;

    typedef enum logic
    {
        ST_IDLE,
        ST_SHIFT
    } st_t;

    // control broadcast from the sequencer to every cell
    typedef struct packed
    {
        logic               load;
        logic               shift;
        logic               wr;
        logic               phase_zero;
        logic [PHASE_W-1:0] thresh;
    } cell_ctrl_t;

endpackage

>>> hw/rtl/srpwm_cell.sv
// One channel cell: brightness level, latched on bit and one shift stage.
// Depends on srpwm_pkg.
module srpwm_cell
    import srpwm_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  cell_ctrl_t         ctrl,
    input  logic               wr_sel,
    input  logic [LEVEL_W-1:0] wr_level,
    input  logic               shift_in,
    output logic               shift_out
);

    logic [LEVEL_W-1:0] level_reg;
    logic [LEVEL_W-1:0] level_next;
    logic               on_reg;
    logic               on_next;
    logic               sh_reg;
    logic               sh_next;

    always_comb
    begin
        on_next = on_reg;
        if (ctrl.load)
        begin
            if (ctrl.phase_zero)
            begin
                on_next = (level_reg != '0);
            end
            else if ({1'b0, level_reg} < ctrl.thresh)
            begin
                on_next = 1'b0;
            end
        end
    end

    always_comb
    begin
        // load wins over shift when a tick arrives on the last bit
        if (ctrl.load)
        begin
            sh_next = on_next;
        end
        else if (ctrl.shift)
        begin
            sh_next = shift_in;
        end
        else
        begin
            sh_next = sh_reg;
        end
        level_next = (ctrl.wr && wr_sel) ? wr_level : level_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            level_reg <= '0;
            on_reg    <= 1'b0;
            sh_reg    <= 1'b0;
        end
        else
        begin
            level_reg <= level_next;
            on_reg    <= on_next;
            sh_reg    <= sh_next;
        end
    end

    assign shift_out = sh_reg;

endmodule

>>> hw/rtl/srpwm_ctrl.sv
// Sequencer: configuration registers, frame phase, bit counter and handshakes.
// Depends on srpwm_pkg; drives the cell_ctrl_t broadcast to the cell chain.
module srpwm_ctrl
    import srpwm_pkg::*;
#(
    parameter int CHANNELS = 8
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  item_valid,
    output logic                  item_stall,
    input  logic                  mode,
    output logic                  result_valid,
    input  logic                  result_stall,
    input  logic                  chain_bit,
    output logic                  data_bit,
    output logic [SEL_W-1:0]      bit_channel,
    output logic                  strobe_last,
    output logic [PHASE_W-1:0]    frame_index,
    output cell_ctrl_t            ctrl
);

    localparam int CNT_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam logic [CNT_W-1:0] CNT_TOP = CNT_W'(CHANNELS - 1);

    st_t                state_reg;
    st_t                state_next;
    logic [CNT_W-1:0]   cnt_reg;
    logic [CNT_W-1:0]   cnt_next;
    logic [PHASE_W-1:0] phase_reg;
    logic [PHASE_W-1:0] phase_next;
    logic [PHASE_W-1:0] fidx_reg;
    logic [PHASE_W-1:0] fidx_next;
    logic               inv_reg;
    logic [PHASE_W-1:0] depth_reg;

    logic               item_acc;
    logic               tick_acc;
    logic               res_acc;
    logic               last;
    logic [PHASE_W-1:0] eff_phase;

    assign item_acc = item_valid && !item_stall;
    assign tick_acc = item_acc && mode;
    assign res_acc  = result_valid && !result_stall;
    assign last     = (cnt_reg == '0);

    // restart the cycle when depth was lowered below the current phase
    assign eff_phase = (phase_reg > depth_reg) ? '0 : phase_reg;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (tick_acc)
                begin
                    state_next = ST_SHIFT;
                end
            end
            ST_SHIFT:
            begin
                if (tick_acc)
                begin
                    state_next = ST_SHIFT;
                end
                else if (res_acc && last)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        result_valid = 1'b0;
        item_stall   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                result_valid = 1'b0;
                item_stall   = 1'b0;
            end
            ST_SHIFT:
            begin
                result_valid = 1'b1;
                // take the next transaction as the last bit leaves
                item_stall   = !(last && !result_stall);
            end
            default:
            begin
                result_valid = 1'b0;
                item_stall   = 1'b1;
            end
        endcase
    end

    always_comb
    begin
        cnt_next   = cnt_reg;
        phase_next = phase_reg;
        fidx_next  = fidx_reg;
        if (tick_acc)
        begin
            cnt_next   = CNT_TOP;
            fidx_next  = eff_phase;
            phase_next = (eff_phase >= depth_reg) ? '0 : eff_phase + 1'b1;
        end
        else if (res_acc)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
            phase_reg <= '0;
            fidx_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            phase_reg <= phase_next;
            fidx_reg  <= fidx_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            inv_reg   <= 1'b0;
            depth_reg <= DEPTH_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_INVERT: inv_reg   <= cfg_data[0];
                REG_DEPTH:  depth_reg <= cfg_data;
                default:    ;
            endcase
        end
    end

    always_comb
    begin
        ctrl.load       = tick_acc;
        ctrl.shift      = res_acc;
        ctrl.wr         = item_acc && !mode;
        ctrl.phase_zero = (eff_phase == '0);
        ctrl.thresh     = eff_phase - 1'b1;
    end

    assign data_bit    = chain_bit ^ inv_reg;
    assign bit_channel = SEL_W'(cnt_reg);
    assign strobe_last = last;
    assign frame_index = fidx_reg;

    a_tick_starts_frame: assert property (@(posedge clk) disable iff (!rst_n)
        tick_acc |=> result_valid && cnt_reg == CNT_TOP)
        else $error("tick did not start a full frame");

    a_frame_ends: assert property (@(posedge clk) disable iff (!rst_n)
        res_acc && last && !tick_acc |=> !result_valid)
        else $error("results continue past the frame's last bit");

    a_accept_only_at_end: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_SHIFT && !item_stall |-> last && res_acc)
        else $error("input taken in the middle of a frame");

    a_index_holds: assert property (@(posedge clk) disable iff (!rst_n)
        res_acc && !last |=> result_valid && $stable(fidx_reg))
        else $error("frame index changed inside a frame");

endmodule

>>> hw/rtl/shift_register_pwm_frame_generator_unit.sv
// Top level of the shift register PWM frame generator: sequencer and cell chain.
// Depends on srpwm_pkg, srpwm_ctrl and srpwm_cell.
//
//  channel  | handshake                  | payload
//  ---------+----------------------------+------------------------------------------
//  item     | item_valid / item_stall    | mode, channel_sel, level_value
//  result   | result_valid / result_stall| data_bit, bit_channel, strobe_last, frame_index
//  config   | cfg_we                     | cfg_index, cfg_data
//
// A level write gives no result. A tick loads every cell, then shifts the chain
// one bit per result: CHANNELS results per tick, with the next item taken as the
// last bit of a frame is accepted.
// Reset clears all levels, lit bits and the frame phase; depth resets to 256.
// A stalled result holds the whole chain.
module shift_register_pwm_frame_generator_unit
    import srpwm_pkg::*;
#(
    parameter int CHANNELS = 8
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  item_valid,
    output logic                  item_stall,
    input  logic                  mode,
    input  logic [SEL_W-1:0]      channel_sel,
    input  logic [LEVEL_W-1:0]    level_value,
    output logic                  result_valid,
    input  logic                  result_stall,
    output logic                  data_bit,
    output logic [SEL_W-1:0]      bit_channel,
    output logic                  strobe_last,
    output logic [PHASE_W-1:0]    frame_index
);

    cell_ctrl_t           ctrl;
    logic [CHANNELS-1:0]  sh_chain;

    srpwm_ctrl #(
        .CHANNELS (CHANNELS)
    ) u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .mode         (mode),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .chain_bit    (sh_chain[CHANNELS-1]),
        .data_bit     (data_bit),
        .bit_channel  (bit_channel),
        .strobe_last  (strobe_last),
        .frame_index  (frame_index),
        .ctrl         (ctrl)
    );

    // highest channel sits at the chain's output end
    for (genvar i = 0; i < CHANNELS; i++)
    begin : g_cell
        logic sh_in;
        logic wr_sel;

        if (i == 0)
        begin : g_first
            assign sh_in = 1'b0;
        end
        else
        begin : g_next
            assign sh_in = sh_chain[i-1];
        end

        assign wr_sel = (32'(channel_sel) == i);

        srpwm_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .ctrl      (ctrl),
            .wr_sel    (wr_sel),
            .wr_level  (level_value),
            .shift_in  (sh_in),
            .shift_out (sh_chain[i])
        );
    end

endmodule
